// ----- hdl/tbdc_pkg.sv -----
// shared types and constants for the three-button debouncer with chord detection
// no dependencies; imported by every module of the block
`default_nettype none

package tbdc_pkg;

  // button lane positions in the level vectors
  localparam int unsigned NumButtons = 3;
  localparam int unsigned BtnLeft    = 0;
  localparam int unsigned BtnOk      = 1;
  localparam int unsigned BtnRight   = 2;

  // configuration register indexes
  localparam logic CfgDebounce  = 1'b0;
  localparam logic CfgChordHold = 1'b1;

  // reset values of the configuration registers
  localparam logic [15:0] DebounceReset  = 16'd30;
  localparam logic [15:0] ChordHoldReset = 16'd1000;

  // event codes
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_MODE  = 3'd1,
    EV_BACK  = 3'd2,
    EV_OK    = 3'd3,
    EV_LEFT  = 3'd4,
    EV_RIGHT = 3'd5
  } event_e;

  // one debounced lane after an update
  typedef struct packed {
    logic stable;
    logic press;
    logic rel;
  } lane_t;

  // all debounced lanes, as handed to the event logic
  typedef struct packed {
    logic [NumButtons-1:0] stable;
    logic [NumButtons-1:0] press;
    logic [NumButtons-1:0] rel;
  } edges_t;

endpackage

`default_nettype wire

// ----- hdl/three_button_debounce_chord.sv -----
// Three-button debouncer with chord detection, top level.
// Each request carries active-low levels for left, ok and right, a wrapping
// millisecond timestamp and a take bit; each request gives exactly one result
// with the event code (none unless take is set) and the debounced levels.
// Channels use valid/stall: a request is taken when in_valid_i is high and
// in_stall_o is low, a result when out_valid_o is high and out_stall_i is low.
// A request lands in the input register, and the debounce, chord and latch
// logic then runs from it into the result register.
// Throughput is one request per cycle while the receiver does not stall.
// While the receiver stalls, the result register holds and one more request
// can wait in the input register before in_stall_o rises.
// Reset clears both registers, sets all levels to released, clears the chord
// state and the latch, and loads debounce 30 ms and chord hold 1000 ms.
// The config port (cfg_we_i, cfg_index_i, cfg_wdata_i) writes index 0 for the
// debounce time and index 1 for the chord hold time; write only while idle.
// depends on tbdc_pkg, tbdc_lane, tbdc_event
`default_nettype none

module three_button_debounce_chord
  import tbdc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  button_levels_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        take_event_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_code_o,
  output logic [2:0]       stable_levels_o
);

  logic [15:0] debounce_q;
  logic [15:0] chord_hold_q;

  logic        s1_valid_q;
  logic [2:0]  s1_levels_q;
  logic [31:0] s1_now_q;
  logic        s1_take_q;

  logic        out_valid_q;
  event_e      event_code_q;
  logic [2:0]  stable_levels_q;

  logic        res_ready;
  logic        s1_ready;
  logic        fire;
  lane_t       lanes [NumButtons];
  edges_t      edges;
  event_e      code;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      chord_hold_q <= ChordHoldReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDebounce:  debounce_q   <= cfg_wdata_i;
        CfgChordHold: chord_hold_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // handshake between the two register stages
  assign res_ready  = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && res_ready;
  assign s1_ready   = !s1_valid_q || res_ready;
  assign in_stall_o = !s1_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_levels_q <= button_levels_i;
      s1_now_q    <= now_ms_i;
      s1_take_q   <= take_event_i;
    end
  end

  // one debounce lane per button
  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    tbdc_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .fire_i        (fire),
      .level_i       (s1_levels_q[g]),
      .now_ms_i      (s1_now_q),
      .debounce_ms_i (debounce_q),
      .lane_o        (lanes[g])
    );
    assign edges.stable[g] = lanes[g].stable;
    assign edges.press[g]  = lanes[g].press;
    assign edges.rel[g]    = lanes[g].rel;
  end

  // chord and event logic
  tbdc_event u_event (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .now_ms_i        (s1_now_q),
    .take_i          (s1_take_q),
    .chord_hold_ms_i (chord_hold_q),
    .edges_i         (edges),
    .code_o          (code)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      event_code_q    <= code;
      stable_levels_q <= edges.stable;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = event_code_q;
  assign stable_levels_o = stable_levels_q;

  // a stalled result blocks the state update
  a_no_fire_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !fire
  ) else $error("state advanced while result stalled");

  // without a take the result carries no event
  a_no_take_no_event: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fire && !s1_take_q |=> event_code_q == EV_NONE
  ) else $error("event reported without take");

  // back-pressure only when the input register holds a request
  a_stall_needs_item: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q
  ) else $error("stall raised with free room");

  // a moved request always produces a result
  a_fire_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q
  ) else $error("request lost between stages");

endmodule

`default_nettype wire

// ----- hdl/tbdc_lane.sv -----
// debounce of one active-low button: raw level, change time and stable level
// depends on tbdc_pkg
`default_nettype none

module tbdc_lane
  import tbdc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic        level_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [15:0] debounce_ms_i,
  output lane_t            lane_o
);

  logic        raw_q, raw_d;
  logic        stable_q, stable_d;
  logic [31:0] change_q, change_d;
  logic [31:0] elapsed;
  logic        settled;

  // track the raw level and when it last changed
  always_comb begin
    raw_d    = level_i;
    change_d = (level_i != raw_q) ? now_ms_i : change_q;
  end

  // wrapping elapsed time against the debounce time
  assign elapsed = now_ms_i - change_d;
  assign settled = elapsed >= {16'd0, debounce_ms_i};

  // stable level update and edge detection
  always_comb begin
    stable_d      = stable_q;
    lane_o.press  = 1'b0;
    lane_o.rel    = 1'b0;
    if (settled && (level_i != stable_q)) begin
      stable_d     = level_i;
      lane_o.press = ~level_i;
      lane_o.rel   = level_i;
    end
    lane_o.stable = stable_d;
  end

  // lane state, advanced once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b1;
      stable_q <= 1'b1;
      change_q <= 32'd0;
    end else if (fire_i) begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      change_q <= change_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tbdc_event.sv -----
// chord detection, press/release event rules and the one-entry event latch
// depends on tbdc_pkg
`default_nettype none

module tbdc_event
  import tbdc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        take_i,
  input  wire logic [15:0] chord_hold_ms_i,
  input  wire edges_t      edges_i,
  output event_e           code_o
);

  logic        left_armed_q, left_armed_d;
  logic        right_armed_q, right_armed_d;
  logic        chord_on_q, chord_on_d;
  logic        chord_fired_q, chord_fired_d;
  logic [31:0] chord_start_q, chord_start_d;
  event_e      latch_q, latch_d;

  logic        left_down, right_down;
  logic        post;
  event_e      post_code;
  event_e      latch_post;
  logic [31:0] chord_elapsed;
  logic        chord_long;

  assign left_down  = ~edges_i.stable[BtnLeft];
  assign right_down = ~edges_i.stable[BtnRight];

  // chord start is now when a chord begins in this request
  assign chord_start_d = (left_down && right_down && !chord_on_q) ? now_ms_i : chord_start_q;
  assign chord_elapsed = now_ms_i - chord_start_d;
  assign chord_long    = chord_elapsed >= {16'd0, chord_hold_ms_i};

  // event rules, chord first, then ok, left, right
  always_comb begin
    left_armed_d  = left_armed_q | edges_i.press[BtnLeft];
    right_armed_d = right_armed_q | edges_i.press[BtnRight];
    chord_on_d    = chord_on_q;
    chord_fired_d = chord_fired_q;
    post          = 1'b0;
    post_code     = EV_NONE;
    if (left_down && right_down) begin
      if (!chord_on_q) begin
        chord_on_d    = 1'b1;
        chord_fired_d = 1'b0;
      end
      if (!chord_fired_d && chord_long) begin
        chord_fired_d = 1'b1;
        left_armed_d  = 1'b0;
        right_armed_d = 1'b0;
        post          = 1'b1;
        post_code     = EV_MODE;
      end
    end else if (chord_on_q) begin
      if (!left_down && !right_down) begin
        chord_on_d    = 1'b0;
        chord_fired_d = 1'b0;
        left_armed_d  = 1'b0;
        right_armed_d = 1'b0;
        if (!chord_fired_q) begin
          post      = 1'b1;
          post_code = EV_BACK;
        end
      end
    end else if (edges_i.press[BtnOk]) begin
      post      = 1'b1;
      post_code = EV_OK;
    end else if (edges_i.rel[BtnLeft] && left_armed_d) begin
      left_armed_d = 1'b0;
      post         = 1'b1;
      post_code    = EV_LEFT;
    end else if (edges_i.rel[BtnRight] && right_armed_d) begin
      right_armed_d = 1'b0;
      post          = 1'b1;
      post_code     = EV_RIGHT;
    end
  end

  // latch keeps the first event; a take reads it out and clears it
  always_comb begin
    latch_post = (post && (latch_q == EV_NONE)) ? post_code : latch_q;
    if (take_i) begin
      code_o  = latch_post;
      latch_d = EV_NONE;
    end else begin
      code_o  = EV_NONE;
      latch_d = latch_post;
    end
  end

  // event state, advanced once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_armed_q  <= 1'b0;
      right_armed_q <= 1'b0;
      chord_on_q    <= 1'b0;
      chord_fired_q <= 1'b0;
      chord_start_q <= 32'd0;
      latch_q       <= EV_NONE;
    end else if (fire_i) begin
      left_armed_q  <= left_armed_d;
      right_armed_q <= right_armed_d;
      chord_on_q    <= chord_on_d;
      chord_fired_q <= chord_fired_d;
      chord_start_q <= chord_start_d;
      latch_q       <= latch_d;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_three_button_debounce_chord.sv -----
// testbench for three_button_debounce_chord: directed table, then random button sequences
// checks every result against an internal debounce and chord predictor or a typed directed expectation; needs tbdc_pkg
`timescale 1ns / 1ps

module tb_three_button_debounce_chord;
  import tbdc_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 200;

  typedef struct packed {
    event_e     code;
    logic [2:0] levels;
  } sample_result_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_TIMING
  } row_kind_e;

  // timing rows carry {chord hold, debounce} in stamp_ms
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  levels;
    logic [31:0] stamp_ms;
    logic        take;
    logic        typed;
    event_e      code;
    logic [2:0]  stable;
  } directed_row_t;

  // dut signals
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic        cfg_index   = 1'b0;
  logic [15:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall_o;
  logic [2:0]  levels_q    = 3'b111;
  logic [31:0] now_q       = '0;
  logic        take_q      = 1'b0;
  logic        out_valid_o;
  logic        out_stall   = 1'b0;
  logic [2:0]  event_code_o;
  logic [2:0]  stable_levels_o;

  // predictor state
  logic [15:0] debounce_cfg = DebounceReset;
  logic [15:0] chord_cfg    = ChordHoldReset;
  logic [2:0]  seen_level    = 3'b111;
  logic [2:0]  settled_level = 3'b111;
  logic [31:0] seen_since_ms [NumButtons] = '{default: '0};
  logic        left_ready    = 1'b0;
  logic        right_ready   = 1'b0;
  logic        chord_held    = 1'b0;
  logic        chord_done    = 1'b0;
  logic [31:0] chord_since_ms = '0;
  event_e      held_event    = EV_NONE;

  // bookkeeping
  sample_result_t pending_events [$];
  directed_row_t  directed_rows [28];
  logic [31:0]    clock_ms      = '0;
  int unsigned    samples_sent  = 0;
  int unsigned    quiet_cycles  = 0;
  int             failures      = 0;
  bit             gaps_on       = 1'b1;
  bit             stalls_on     = 1'b1;

  three_button_debounce_chord u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .button_levels_i(levels_q),
    .now_ms_i       (now_q),
    .take_event_i   (take_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .event_code_o   (event_code_o),
    .stable_levels_o(stable_levels_o)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // the latch only takes an event while empty
  function automatic event_e keep_first(event_e held, event_e fresh);
    if (held == EV_NONE) return fresh;
    return held;
  endfunction

  // debounce every lane, run chord and single-button events, then read the latch
  task automatic debounce_and_detect(input logic [2:0] lv, input logic [31:0] now_ms,
                                     input logic take, output sample_result_t res);
    logic [2:0]  press;
    logic [2:0]  rel;
    logic [31:0] elapsed;
    logic        left_dn;
    logic        right_dn;
    logic        short_chord;
    press = '0;
    rel   = '0;
    for (int i = 0; i < NumButtons; i++) begin
      if (lv[i] != seen_level[i]) begin
        seen_level[i]    = lv[i];
        seen_since_ms[i] = now_ms;
      end
      elapsed = now_ms - seen_since_ms[i];
      if (elapsed >= {16'd0, debounce_cfg} && lv[i] != settled_level[i]) begin
        settled_level[i] = lv[i];
        if (lv[i]) rel[i] = 1'b1;
        else press[i] = 1'b1;
      end
    end
    left_dn  = !settled_level[BtnLeft];
    right_dn = !settled_level[BtnRight];
    if (press[BtnLeft]) left_ready = 1'b1;
    if (press[BtnRight]) right_ready = 1'b1;
    if (left_dn && right_dn) begin
      if (!chord_held) begin
        chord_held     = 1'b1;
        chord_done     = 1'b0;
        chord_since_ms = now_ms;
      end
      elapsed = now_ms - chord_since_ms;
      if (!chord_done && elapsed >= {16'd0, chord_cfg}) begin
        chord_done  = 1'b1;
        left_ready  = 1'b0;
        right_ready = 1'b0;
        held_event  = keep_first(held_event, EV_MODE);
      end
    end else if (chord_held) begin
      // chord ends only once both sides are up
      if (!left_dn && !right_dn) begin
        short_chord = !chord_done;
        chord_held  = 1'b0;
        chord_done  = 1'b0;
        left_ready  = 1'b0;
        right_ready = 1'b0;
        if (short_chord) held_event = keep_first(held_event, EV_BACK);
      end
    end else if (press[BtnOk]) begin
      held_event = keep_first(held_event, EV_OK);
    end else if (rel[BtnLeft] && left_ready) begin
      left_ready = 1'b0;
      held_event = keep_first(held_event, EV_LEFT);
    end else if (rel[BtnRight] && right_ready) begin
      right_ready = 1'b0;
      held_event = keep_first(held_event, EV_RIGHT);
    end
    res.code   = take ? held_event : EV_NONE;
    res.levels = settled_level;
    if (take) held_event = EV_NONE;
  endtask

  // drive one request, wait for it to be taken, queue its expected result
  task automatic send_sample(input logic [2:0] lv, input logic [31:0] now_ms,
                             input logic take, input logic typed,
                             input sample_result_t typed_res);
    sample_result_t predicted;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    levels_q <= lv;
    now_q    <= now_ms;
    take_q   <= take;
    do @(posedge clk_i); while (in_stall_o);
    debounce_and_detect(lv, now_ms, take, predicted);
    pending_events.push_back(typed ? typed_res : predicted);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // write both timing registers once the block has drained
  task automatic write_timing(input logic [15:0] deb, input logic [15:0] hold);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CfgDebounce;
    cfg_wdata <= deb;
    @(negedge clk_i);
    cfg_index <= CfgChordHold;
    cfg_wdata <= hold;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    debounce_cfg = deb;
    chord_cfg    = hold;
  endtask

  // keep one level pattern until at least span ms have passed
  task automatic hold_levels(input logic [2:0] lv, input int unsigned span,
                             input int unsigned step);
    logic [31:0] t0;
    logic [31:0] elapsed;
    t0 = clock_ms;
    do begin
      elapsed = clock_ms - t0;
      send_sample(lv, clock_ms, $urandom_range(0, 2) == 0, 1'b0, '0);
      clock_ms += $urandom_range(1, step);
    end while (elapsed < span);
  endtask

  // one random button gesture: tap, chord, bounce or a jump in time
  task automatic run_gesture();
    logic [2:0]  lv;
    int unsigned pick;
    int unsigned step;
    int unsigned span;
    step = ((debounce_cfg > chord_cfg / 8) ? debounce_cfg : chord_cfg / 8) / 4 + 4;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // single button tap
      lv = 3'b111;
      lv[$urandom_range(0, 2)] = 1'b0;
      hold_levels(lv, debounce_cfg + $urandom_range(0, step), step);
      hold_levels(3'b111, debounce_cfg + $urandom_range(0, step), step);
    end else if (pick < 70) begin
      // chord, sometimes staggered, sometimes with ok down too
      if ($urandom_range(0, 1) == 1) begin
        lv = ($urandom_range(0, 1) == 1) ? 3'b110 : 3'b011;
        hold_levels(lv, $urandom_range(0, debounce_cfg), step);
      end
      lv = ($urandom_range(0, 3) == 0) ? 3'b000 : 3'b010;
      if ($urandom_range(0, 1) == 1)
        span = debounce_cfg + chord_cfg + $urandom_range(0, step);
      else
        span = debounce_cfg + $urandom_range(0, chord_cfg);
      hold_levels(lv, span, step);
      lv = ($urandom_range(0, 1) == 1) ? 3'b011 : 3'b110;
      hold_levels(lv, debounce_cfg + $urandom_range(0, step), step);
      hold_levels(3'b111, debounce_cfg + $urandom_range(0, step), step);
    end else if (pick < 90) begin
      // contact bounce shorter than the debounce time
      repeat ($urandom_range(2, 6)) begin
        send_sample(3'($urandom_range(0, 7)), clock_ms, $urandom_range(0, 2) == 0,
                    1'b0, '0);
        clock_ms += $urandom_range(0, debounce_cfg / 2 + 1);
      end
    end else begin
      // jump anywhere on the timestamp circle
      clock_ms = $urandom();
      send_sample(3'($urandom_range(0, 7)), clock_ms, $urandom_range(0, 1) == 1,
                  1'b0, '0);
    end
  endtask

  // receiver stall bursts
  initial begin : result_stalls
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    sample_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("result with no request outstanding: event_code %0d stable_levels %b",
               event_code_o, stable_levels_o);
        failures++;
      end else begin
        want = pending_events.pop_front();
        if (event_code_o !== want.code) begin
          $error("event_code: expected %0d, actual %0d", want.code, event_code_o);
          failures++;
        end
        if (stable_levels_o !== want.levels) begin
          $error("stable_levels: expected %b, actual %b", want.levels, stable_levels_o);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    directed_row_t row;
    logic [15:0]   deb;
    logic [15:0]   hold;
    int unsigned   phase_end;

    directed_rows = '{
      // idle after reset
      '{ROW_SAMPLE, 3'b111, 32'd0,    1'b1, 1'b1, EV_NONE, 3'b111},
      // ok press settles exactly at the debounce time
      '{ROW_SAMPLE, 3'b101, 32'd100,  1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b101, 32'd130,  1'b1, 1'b1, EV_OK,   3'b101},
      // ok release and left press together
      '{ROW_SAMPLE, 3'b110, 32'd200,  1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b110, 32'd230,  1'b0, 1'b0, EV_NONE, 3'b000},
      // left release while right bounces
      '{ROW_SAMPLE, 3'b011, 32'd300,  1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b111, 32'd310,  1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b111, 32'd330,  1'b0, 1'b0, EV_NONE, 3'b000},
      // ok press dropped while the latch holds left
      '{ROW_SAMPLE, 3'b101, 32'd340,  1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b101, 32'd400,  1'b1, 1'b0, EV_NONE, 3'b000},
      // long chord, then one side up, then both
      '{ROW_SAMPLE, 3'b010, 32'd500,  1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b010, 32'd600,  1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b011, 32'd1600, 1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b011, 32'd1700, 1'b1, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b111, 32'd1800, 1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b111, 32'd1900, 1'b1, 1'b0, EV_NONE, 3'b000},
      // short chord gives back
      '{ROW_SAMPLE, 3'b010, 32'd2000, 1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b010, 32'd2100, 1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b111, 32'd2200, 1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b111, 32'd2300, 1'b1, 1'b1, EV_BACK, 3'b111},
      // all pressed across the timestamp wrap, chord wins over ok
      '{ROW_SAMPLE, 3'b000, 32'hFFFF_FFF0, 1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b000, 32'h0000_000E, 1'b1, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b111, 32'h0000_0040, 1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b111, 32'h0000_0060, 1'b1, 1'b1, EV_BACK, 3'b111},
      // zero debounce and zero chord hold act in the same sample
      '{ROW_TIMING, 3'b000, 32'h0000_0000, 1'b0, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b110, 32'h0000_0100, 1'b1, 1'b0, EV_NONE, 3'b000},
      '{ROW_SAMPLE, 3'b010, 32'h0000_0101, 1'b1, 1'b1, EV_MODE, 3'b010},
      '{ROW_SAMPLE, 3'b111, 32'h0000_0102, 1'b1, 1'b0, EV_NONE, 3'b000}
    };

    // reset
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_TIMING)
        write_timing(row.stamp_ms[15:0], row.stamp_ms[31:16]);
      else
        send_sample(row.levels, row.stamp_ms, row.take, row.typed,
                    sample_result_t'{row.code, row.stable});
    end

    // random part, one timing setting per phase
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin deb = 16'd0;     hold = 16'd0;     end
        1: begin deb = 16'hFFFF;  hold = 16'hFFFF;  end
        2: begin deb = 16'd0;     hold = 16'hFFFF;  end
        3: begin deb = 16'hFFFF;  hold = 16'd0;     end
        4, 5: begin
          deb  = 16'($urandom_range(1, 60));
          hold = 16'($urandom_range(0, 400));
        end
        6: begin deb = 16'd12;    hold = 16'd150;   end
        default: begin deb = DebounceReset; hold = ChordHoldReset; end
      endcase
      write_timing(deb, hold);
      gaps_on   = (p != 3) && (p != NumPhases - 1);
      stalls_on = (p != 4) && (p != NumPhases - 1);
      clock_ms  = $urandom();
      phase_end = samples_sent + PhaseItems;
      while (samples_sent < phase_end) run_gesture();
    end

    // drain
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tbdc_pkg.sv
hdl/tbdc_lane.sv
hdl/tbdc_event.sv
hdl/three_button_debounce_chord.sv
tb/tb_three_button_debounce_chord.sv
